// ===== design/assert_macros.svh =====
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FPP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fpp_pkg.sv =====
// Types, constants and tables of the fisheye point projection pipeline.
package fpp_pkg;

    localparam int PT_W        = 32;   // point coordinate width
    localparam int CFG_W       = 24;   // configuration register width
    localparam int ROOT_W      = 32;   // radius width, one pipeline step per bit
    localparam int REM_W       = 65;   // square root remainder
    localparam int CRD_W       = 36;   // CORDIC x/y datapath
    localparam int ANG_W       = 34;   // CORDIC angle accumulator, Q30
    localparam int CORDIC_STEPS = 30;
    localparam int QUO_W       = 21;   // direction ratio, Q20, at most 1.0
    localparam int DIV_W       = 53;   // dividend |x| << 20
    localparam int TH_W        = 22;   // theta in Q20
    localparam int DM_W        = 39;   // |d| in Q20
    localparam int ACC_W       = 62;   // distortion sum in Q40

    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [ANG_W-1:0]        PI_Q30      = 34'd3373259426;

    // register indexes
    localparam logic [3:0] CFG_FOCAL_X  = 4'd0;
    localparam logic [3:0] CFG_FOCAL_Y  = 4'd1;
    localparam logic [3:0] CFG_CENTER_X = 4'd2;
    localparam logic [3:0] CFG_CENTER_Y = 4'd3;
    localparam logic [3:0] CFG_COEF_K1  = 4'd4;
    localparam logic [3:0] CFG_COEF_K2  = 4'd5;
    localparam logic [3:0] CFG_COEF_K3  = 4'd6;
    localparam logic [3:0] CFG_COEF_K4  = 4'd7;

    // reset values
    localparam logic [CFG_W-1:0] FOCAL_RST    = 24'd128000;
    localparam logic [CFG_W-1:0] CENTER_X_RST = 24'd81920;
    localparam logic [CFG_W-1:0] CENTER_Y_RST = 24'd61440;

    typedef struct packed {
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic signed [PT_W-1:0] point_z;
    } fpp_point_t;

    typedef struct packed {
        logic signed [PT_W-1:0] pixel_u;
        logic signed [PT_W-1:0] pixel_v;
        logic                   on_axis;
        logic                   saturated;
    } fpp_pixel_t;

    typedef struct packed {
        logic on_axis;
        logic x_neg;
        logic y_neg;
        logic z_neg;
    } fpp_flags_t;

    // square root pipeline word
    typedef struct packed {
        fpp_flags_t        flags;
        logic [PT_W-1:0]   ax;
        logic [PT_W-1:0]   ay;
        logic [PT_W-1:0]   az;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } fpp_root_t;

    // CORDIC and ratio divider pipeline word
    typedef struct packed {
        fpp_flags_t               flags;
        logic signed [CRD_W-1:0]  px;
        logic signed [CRD_W-1:0]  py;
        logic signed [ANG_W-1:0]  ang;
        logic [ROOT_W-1:0]        den;
        logic [DIV_W-1:0]         rem_x;
        logic [DIV_W-1:0]         rem_y;
        logic [QUO_W-1:0]         quo_x;
        logic [QUO_W-1:0]         quo_y;
    } fpp_rot_t;

    // side data riding along the polynomial stages
    typedef struct packed {
        fpp_flags_t       flags;
        logic [QUO_W-1:0] quo_x;
        logic [QUO_W-1:0] quo_y;
    } fpp_side_t;

    // atan(2^-i) in Q30, 2^(30-i) past the table
    function automatic logic [31:0] atan_step(input int unsigned i);
        logic [31:0] v;
        unique case (i)
            0:       v = 32'd843314857;
            1:       v = 32'd497837829;
            2:       v = 32'd263043837;
            3:       v = 32'd133525159;
            4:       v = 32'd67021688;
            5:       v = 32'd33543516;
            6:       v = 32'd16775851;
            7:       v = 32'd8388437;
            8:       v = 32'd4194283;
            9:       v = 32'd2097149;
            10:      v = 32'd1048576;
            default: v = 32'd1 << (30 - i);
        endcase
        return v;
    endfunction

endpackage

// ===== design/fpp_root_step.sv =====
// One bit of the pipelined integer square root.
module fpp_root_step #(
    parameter int BIT = 0
) (
    input  logic                clk,
    input  logic                adv,
    input  fpp_pkg::fpp_root_t  din,
    output fpp_pkg::fpp_root_t  dout
);

    localparam int TW = fpp_pkg::REM_W + 1;

    fpp_pkg::fpp_root_t dout_reg;
    fpp_pkg::fpp_root_t dout_next;
    logic [TW-1:0]      trial;

    always_comb
    begin
        // (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b)
        trial = ({{(TW - fpp_pkg::ROOT_W){1'b0}}, din.root} << (BIT + 1))
              + ({{(TW - 1){1'b0}}, 1'b1} << (2 * BIT));
        dout_next = din;
        if ({1'b0, din.rem} >= trial)
        begin
            dout_next.rem  = din.rem - trial[fpp_pkg::REM_W-1:0];
            dout_next.root = din.root | ({{(fpp_pkg::ROOT_W - 1){1'b0}}, 1'b1} << BIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

// ===== design/fpp_rot_step.sv =====
// One CORDIC vectoring step plus, while STEP is below QUO_W, one quotient bit of each ratio divider.
module fpp_rot_step #(
    parameter int STEP = 0
) (
    input  logic               clk,
    input  logic               adv,
    input  fpp_pkg::fpp_rot_t  din,
    output fpp_pkg::fpp_rot_t  dout
);

    localparam logic signed [fpp_pkg::ANG_W-1:0] ST =
        $signed({2'b00, fpp_pkg::atan_step(STEP)});

    fpp_pkg::fpp_rot_t                   dout_reg;
    fpp_pkg::fpp_rot_t                   dout_next;
    logic signed [fpp_pkg::CRD_W-1:0]    dx;
    logic signed [fpp_pkg::CRD_W-1:0]    dy;
    logic [fpp_pkg::DIV_W-1:0]           rem_x_n;
    logic [fpp_pkg::DIV_W-1:0]           rem_y_n;
    logic [fpp_pkg::QUO_W-1:0]           quo_x_n;
    logic [fpp_pkg::QUO_W-1:0]           quo_y_n;

    generate
        if (STEP < fpp_pkg::QUO_W)
        begin : g_div
            localparam int QB = fpp_pkg::QUO_W - 1 - STEP;
            logic [fpp_pkg::DIV_W-1:0] dsh;

            assign dsh = {{(fpp_pkg::DIV_W - fpp_pkg::ROOT_W){1'b0}}, din.den} << QB;

            always_comb
            begin
                rem_x_n = din.rem_x;
                quo_x_n = din.quo_x;
                rem_y_n = din.rem_y;
                quo_y_n = din.quo_y;
                if (din.rem_x >= dsh)
                begin
                    rem_x_n     = din.rem_x - dsh;
                    quo_x_n[QB] = 1'b1;
                end
                if (din.rem_y >= dsh)
                begin
                    rem_y_n     = din.rem_y - dsh;
                    quo_y_n[QB] = 1'b1;
                end
            end
        end
        else
        begin : g_nodiv
            assign rem_x_n = din.rem_x;
            assign rem_y_n = din.rem_y;
            assign quo_x_n = din.quo_x;
            assign quo_y_n = din.quo_y;
        end
    endgenerate

    always_comb
    begin
        dx        = din.py >>> STEP;
        dy        = din.px >>> STEP;
        dout_next = din;
        if (!din.py[fpp_pkg::CRD_W-1])
        begin
            dout_next.px  = din.px + dx;
            dout_next.py  = din.py - dy;
            dout_next.ang = din.ang + ST;
        end
        else
        begin
            dout_next.px  = din.px - dx;
            dout_next.py  = din.py + dy;
            dout_next.ang = din.ang - ST;
        end
        dout_next.rem_x = rem_x_n;
        dout_next.rem_y = rem_y_n;
        dout_next.quo_x = quo_x_n;
        dout_next.quo_y = quo_y_n;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

// ===== design/fpp_place.sv =====
// Per-axis pixel placement: |d| * ratio * focal, signed offset, center add, clamp.
module fpp_place (
    input  logic                              clk,
    input  logic                              adv,
    input  logic [fpp_pkg::DM_W-1:0]          dm,
    input  logic [fpp_pkg::QUO_W-1:0]         ratio,
    input  logic                              neg,
    input  logic                              axis_in,
    input  logic [fpp_pkg::CFG_W-1:0]         focal,
    input  logic [fpp_pkg::CFG_W-1:0]         center,
    output logic signed [fpp_pkg::PT_W-1:0]   value,
    output logic                              sat,
    output logic                              axis_out
);

    localparam int PW  = 41;   // 20 x 21 partial products
    localparam int TW  = 40;   // t = |d| * ratio >> 20
    localparam int MW  = 44;   // focal x 20 bit partials
    localparam int OW  = 45;   // offset, Q8
    localparam int VW  = 47;   // signed sum before clamp

    // stage A
    logic [PW-1:0] ph_reg, pl_reg;
    logic          neg_a_reg, axis_a_reg;
    // stage B
    logic [TW-1:0] t_reg;
    logic          neg_b_reg, axis_b_reg;
    // stage C
    logic [MW-1:0] m1_reg, m2_reg;
    logic          neg_c_reg, axis_c_reg;
    // stage D
    logic [OW-1:0] off_reg;
    logic          neg_d_reg, axis_d_reg;
    // stage E
    logic signed [fpp_pkg::PT_W-1:0] value_reg, value_next;
    logic                            sat_reg, sat_next;
    logic                            axis_e_reg;

    logic signed [VW-1:0] sum;
    logic signed [VW-1:0] soff;

    always_comb
    begin
        soff = $signed({{(VW - OW){1'b0}}, off_reg});
        sum  = $signed({{(VW - fpp_pkg::CFG_W){1'b0}}, center}) + (neg_d_reg ? -soff : soff);
        value_next = sum[fpp_pkg::PT_W-1:0];
        sat_next   = 1'b0;
        if (axis_d_reg)
        begin
            value_next = $signed({{(fpp_pkg::PT_W - fpp_pkg::CFG_W){1'b0}}, center});
        end
        else if (sum[VW-1:fpp_pkg::PT_W-1] != {(VW - fpp_pkg::PT_W + 1){sum[VW-1]}})
        begin
            // out of 32 bit range: clamp toward the sign
            sat_next   = 1'b1;
            value_next = sum[VW-1] ? {1'b1, {(fpp_pkg::PT_W - 1){1'b0}}}
                                   : {1'b0, {(fpp_pkg::PT_W - 1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ph_reg     <= PW'({{(PW - 19){1'b0}}, dm[38:20]} * {{(PW - 21){1'b0}}, ratio});
            pl_reg     <= PW'({{(PW - 20){1'b0}}, dm[19:0]} * {{(PW - 21){1'b0}}, ratio});
            neg_a_reg  <= neg;
            axis_a_reg <= axis_in;

            t_reg      <= TW'(ph_reg) + TW'(pl_reg[PW-1:20]);
            neg_b_reg  <= neg_a_reg;
            axis_b_reg <= axis_a_reg;

            m1_reg     <= {20'd0, focal} * {24'd0, t_reg[TW-1:20]};
            m2_reg     <= {20'd0, focal} * {24'd0, t_reg[19:0]};
            neg_c_reg  <= neg_b_reg;
            axis_c_reg <= axis_b_reg;

            off_reg    <= {1'b0, m1_reg} + {21'd0, m2_reg[MW-1:20]};
            neg_d_reg  <= neg_c_reg;
            axis_d_reg <= axis_c_reg;

            value_reg  <= value_next;
            sat_reg    <= sat_next;
            axis_e_reg <= axis_d_reg;
        end
    end

    assign value    = value_reg;
    assign sat      = sat_reg;
    assign axis_out = axis_e_reg;

endmodule

// ===== design/fisheye_point_project.sv =====
// Top level of the Kannala-Brandt fisheye point projection pipeline.
//
//  channel  | handshake                  | word
//  ---------+----------------------------+---------------------------------
//  point    | point_valid / point_ready  | fpp_point_t  x, y, z
//  pixel    | pixel_valid / pixel_ready  | fpp_pixel_t  u, v, on_axis, sat
//  config   | cfg_we                     | cfg_index, cfg_data (24 bit)
//
//  Throughput is one word per clock while the output is not held; the
//  pipeline depth is set mostly by the 32 square-root stages and the 30
//  CORDIC stages (the ratio dividers run inside the first 21 CORDIC stages).
//  Reset clears all valid bits and loads the register defaults.
//  A held output word freezes the whole pipeline through one enable;
//  nothing moves, so no word is lost or repeated, and point_ready drops
//  only while a finished word waits at the output.
module fisheye_point_project (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  point_valid,
    output logic                  point_ready,
    input  fpp_pkg::fpp_point_t   point,
    output logic                  pixel_valid,
    input  logic                  pixel_ready,
    output fpp_pkg::fpp_pixel_t   pixel,
    input  logic                  cfg_we,
    input  logic [3:0]            cfg_index,
    input  logic [fpp_pkg::CFG_W-1:0] cfg_data
);

    localparam int ROOT_STEPS = fpp_pkg::ROOT_W;
    localparam int CRD_STEPS  = fpp_pkg::CORDIC_STEPS;
    // front 4, root, select 1, cordic, theta 2, polynomial 7, placement 5
    localparam int LAT = 4 + ROOT_STEPS + 1 + CRD_STEPS + 2 + 7 + 5;

    localparam int W   = fpp_pkg::PT_W;
    localparam int CW  = fpp_pkg::CFG_W;

    // ---------------- configuration registers ----------------
    logic [CW-1:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [CW-1:0] coef_k1_reg, coef_k2_reg, coef_k3_reg, coef_k4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= fpp_pkg::FOCAL_RST;
            focal_y_reg  <= fpp_pkg::FOCAL_RST;
            center_x_reg <= fpp_pkg::CENTER_X_RST;
            center_y_reg <= fpp_pkg::CENTER_Y_RST;
            coef_k1_reg  <= '0;
            coef_k2_reg  <= '0;
            coef_k3_reg  <= '0;
            coef_k4_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fpp_pkg::CFG_FOCAL_X:  focal_x_reg  <= cfg_data;
                fpp_pkg::CFG_FOCAL_Y:  focal_y_reg  <= cfg_data;
                fpp_pkg::CFG_CENTER_X: center_x_reg <= cfg_data;
                fpp_pkg::CFG_CENTER_Y: center_y_reg <= cfg_data;
                fpp_pkg::CFG_COEF_K1:  coef_k1_reg  <= cfg_data;
                fpp_pkg::CFG_COEF_K2:  coef_k2_reg  <= cfg_data;
                fpp_pkg::CFG_COEF_K3:  coef_k3_reg  <= cfg_data;
                fpp_pkg::CFG_COEF_K4:  coef_k4_reg  <= cfg_data;
                default: ; // unmapped index, dropped
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // One enable for every stage; valid bits shift along with the data.
    logic           adv;
    logic [LAT-1:0] valid_reg, valid_next;

    assign adv         = !valid_reg[LAT-1] || pixel_ready;
    assign point_ready = adv;
    assign pixel_valid = valid_reg[LAT-1];
    assign valid_next  = {valid_reg[LAT-2:0], point_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // ---------------- stage 1: magnitudes and signs ----------------
    fpp_pkg::fpp_flags_t flags1_reg, flags1_next;
    logic [W-1:0]        ax1_reg, ay1_reg, az1_reg;

    always_comb
    begin
        flags1_next.on_axis = (point.point_x == '0) && (point.point_y == '0);
        flags1_next.x_neg   = point.point_x[W-1];
        flags1_next.y_neg   = point.point_y[W-1];
        flags1_next.z_neg   = point.point_z[W-1];
    end

    // ---------------- stage 2: common normalizing shift ----------------
    // Shift all three left until the largest reaches 2^29.
    fpp_pkg::fpp_flags_t flags2_reg;
    logic [W-1:0]        ax2_reg, ay2_reg, az2_reg;
    logic [W-1:0]        mag_or;
    logic [4:0]          msb;
    logic [4:0]          sh;

    always_comb
    begin
        mag_or = ax1_reg | ay1_reg | az1_reg;
        msb    = '0;
        for (int i = 0; i < W; i++)
        begin
            if (mag_or[i])
            begin
                msb = 5'(i);
            end
        end
        sh = (msb < 5'd29) ? (5'd29 - msb) : 5'd0;
    end

    // ---------------- stage 3: squares ----------------
    fpp_pkg::fpp_flags_t flags3_reg;
    logic [W-1:0]        ax3_reg, ay3_reg, az3_reg;
    logic [2*W-2:0]      sx3_reg, sy3_reg;
    logic [2*W-1:0]      sqx, sqy;

    assign sqx = {{W{1'b0}}, ax2_reg} * {{W{1'b0}}, ax2_reg};
    assign sqy = {{W{1'b0}}, ay2_reg} * {{W{1'b0}}, ay2_reg};

    // ---------------- stage 4: radius squared ----------------
    fpp_pkg::fpp_root_t root_pipe [ROOT_STEPS+1];
    fpp_pkg::fpp_root_t root_in_reg, root_in_next;

    always_comb
    begin
        root_in_next.flags = flags3_reg;
        root_in_next.ax    = ax3_reg;
        root_in_next.ay    = ay3_reg;
        root_in_next.az    = az3_reg;
        root_in_next.rem   = {2'b00, sx3_reg} + {2'b00, sy3_reg};
        root_in_next.root  = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax1_reg     <= point.point_x[W-1] ? (~point.point_x + 1'b1) : point.point_x;
            ay1_reg     <= point.point_y[W-1] ? (~point.point_y + 1'b1) : point.point_y;
            az1_reg     <= point.point_z[W-1] ? (~point.point_z + 1'b1) : point.point_z;
            flags1_reg  <= flags1_next;

            ax2_reg     <= ax1_reg << sh;
            ay2_reg     <= ay1_reg << sh;
            az2_reg     <= az1_reg << sh;
            flags2_reg  <= flags1_reg;

            sx3_reg     <= sqx[2*W-2:0];
            sy3_reg     <= sqy[2*W-2:0];
            ax3_reg     <= ax2_reg;
            ay3_reg     <= ay2_reg;
            az3_reg     <= az2_reg;
            flags3_reg  <= flags2_reg;

            root_in_reg <= root_in_next;
        end
    end

    // ---------------- square root, one bit per stage ----------------
    assign root_pipe[0] = root_in_reg;

    generate
        for (genvar g = 0; g < ROOT_STEPS; g++)
        begin : g_root
            fpp_root_step #(
                .BIT (ROOT_STEPS - 1 - g)
            ) u_step (
                .clk  (clk),
                .adv  (adv),
                .din  (root_pipe[g]),
                .dout (root_pipe[g+1])
            );
        end
    endgenerate

    // ---------------- select CORDIC vector, seed dividers ----------------
    // z >= 0: vector (z, r); z < 0: vector (r, -z), pi/2 added later.
    fpp_pkg::fpp_rot_t rot_pipe [CRD_STEPS+1];
    fpp_pkg::fpp_rot_t rot_in_reg, rot_in_next;
    fpp_pkg::fpp_root_t root_out;

    assign root_out = root_pipe[ROOT_STEPS];

    always_comb
    begin
        rot_in_next.flags = root_out.flags;
        if (root_out.flags.z_neg)
        begin
            rot_in_next.px = $signed({4'd0, root_out.root});
            rot_in_next.py = $signed({4'd0, root_out.az});
        end
        else
        begin
            rot_in_next.px = $signed({4'd0, root_out.az});
            rot_in_next.py = $signed({4'd0, root_out.root});
        end
        rot_in_next.ang   = '0;
        rot_in_next.den   = root_out.root;
        rot_in_next.rem_x = {1'b0, root_out.ax, 20'd0};
        rot_in_next.rem_y = {1'b0, root_out.ay, 20'd0};
        rot_in_next.quo_x = '0;
        rot_in_next.quo_y = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rot_in_reg <= rot_in_next;
        end
    end

    assign rot_pipe[0] = rot_in_reg;

    generate
        for (genvar g = 0; g < CRD_STEPS; g++)
        begin : g_rot
            fpp_rot_step #(
                .STEP (g)
            ) u_step (
                .clk  (clk),
                .adv  (adv),
                .din  (rot_pipe[g]),
                .dout (rot_pipe[g+1])
            );
        end
    endgenerate

    // ---------------- theta: clamp, quadrant, round to Q20 ----------------
    fpp_pkg::fpp_rot_t              rot_out;
    fpp_pkg::fpp_side_t             side_t1_reg, side_t1_next, side_t2_reg;
    logic [fpp_pkg::ANG_W-1:0]      ang_c;
    logic [fpp_pkg::ANG_W-1:0]      theta1_reg, theta1_next;
    logic [fpp_pkg::ANG_W-1:0]      theta_c;
    logic [fpp_pkg::ANG_W-1:0]      theta_r;
    logic [fpp_pkg::TH_W-1:0]       th2_reg;

    assign rot_out = rot_pipe[CRD_STEPS];

    always_comb
    begin
        if (rot_out.ang[fpp_pkg::ANG_W-1])
        begin
            ang_c = '0;
        end
        else if (rot_out.ang > fpp_pkg::HALF_PI_Q30)
        begin
            ang_c = fpp_pkg::HALF_PI_Q30;
        end
        else
        begin
            ang_c = rot_out.ang;
        end
        theta1_next = rot_out.flags.z_neg ? (ang_c + fpp_pkg::HALF_PI_Q30) : ang_c;
        side_t1_next.flags = rot_out.flags;
        side_t1_next.quo_x = rot_out.quo_x;
        side_t1_next.quo_y = rot_out.quo_y;

        theta_c = (theta1_reg > fpp_pkg::PI_Q30) ? fpp_pkg::PI_Q30 : theta1_reg;
        theta_r = theta_c + 34'd512;
    end

    // ---------------- distortion polynomial ----------------
    // p1 t2, p2 t3, p3 t5 + k1, p4 t7 + k2, p5 t9 + k3, p6 + k4, p7 |d|
    fpp_pkg::fpp_side_t side_p1_reg, side_p2_reg, side_p3_reg, side_p4_reg;
    fpp_pkg::fpp_side_t side_p5_reg, side_p6_reg, side_p7_reg;
    logic [fpp_pkg::TH_W-1:0]    th_p1_reg, th_p2_reg;
    logic [23:0]                 t2_p1_reg, t2_p2_reg, t2_p3_reg, t2_p4_reg;
    logic [24:0]                 t3_p2_reg;
    logic [28:0]                 t5_p3_reg;
    logic [31:0]                 t7_p4_reg;
    logic [34:0]                 t9_p5_reg;
    logic signed [fpp_pkg::ACC_W-1:0] acc_p3_reg, acc_p4_reg, acc_p5_reg, acc_p6_reg;
    logic signed [fpp_pkg::ACC_W-1:0] acc_p3_next, acc_p4_next, acc_p5_next, acc_p6_next;
    logic [fpp_pkg::DM_W-1:0]    dm_p7_reg;
    logic                        dneg_p7_reg;

    logic [43:0] m_t2;
    logic [45:0] m_t3;
    logic [52:0] m_t5;
    logic [55:0] m_t7;
    logic [58:0] m_t9;
    logic signed [fpp_pkg::ACC_W-1:0] d20;
    logic signed [fpp_pkg::ACC_W-1:0] dmag;

    always_comb
    begin
        m_t2 = {22'd0, th2_reg} * {22'd0, th2_reg};
        m_t3 = {22'd0, t2_p1_reg} * {24'd0, th_p1_reg};
        m_t5 = {28'd0, t3_p2_reg} * {29'd0, t2_p2_reg};
        m_t7 = {27'd0, t5_p3_reg} * {32'd0, t2_p3_reg};
        m_t9 = {27'd0, t7_p4_reg} * {35'd0, t2_p4_reg};

        acc_p3_next = $signed({20'd0, th_p2_reg, 20'd0})
                    + $signed(coef_k1_reg) * $signed({1'b0, t3_p2_reg});
        acc_p4_next = acc_p3_reg + $signed(coef_k2_reg) * $signed({1'b0, t5_p3_reg});
        acc_p5_next = acc_p4_reg + $signed(coef_k3_reg) * $signed({1'b0, t7_p4_reg});
        acc_p6_next = acc_p5_reg + $signed(coef_k4_reg) * $signed({1'b0, t9_p5_reg});

        d20  = acc_p6_reg >>> 20;
        dmag = d20[fpp_pkg::ACC_W-1] ? -d20 : d20;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            theta1_reg  <= theta1_next;
            side_t1_reg <= side_t1_next;

            th2_reg     <= theta_r[31:10];
            side_t2_reg <= side_t1_reg;

            th_p1_reg   <= th2_reg;
            t2_p1_reg   <= m_t2[43:20];
            side_p1_reg <= side_t2_reg;

            th_p2_reg   <= th_p1_reg;
            t2_p2_reg   <= t2_p1_reg;
            t3_p2_reg   <= m_t3[44:20];
            side_p2_reg <= side_p1_reg;

            t2_p3_reg   <= t2_p2_reg;
            t5_p3_reg   <= m_t5[48:20];
            acc_p3_reg  <= acc_p3_next;
            side_p3_reg <= side_p2_reg;

            t2_p4_reg   <= t2_p3_reg;
            t7_p4_reg   <= m_t7[51:20];
            acc_p4_reg  <= acc_p4_next;
            side_p4_reg <= side_p3_reg;

            t9_p5_reg   <= m_t9[54:20];
            acc_p5_reg  <= acc_p5_next;
            side_p5_reg <= side_p4_reg;

            acc_p6_reg  <= acc_p6_next;
            side_p6_reg <= side_p5_reg;

            dm_p7_reg   <= dmag[fpp_pkg::DM_W-1:0];
            dneg_p7_reg <= acc_p6_reg[fpp_pkg::ACC_W-1];
            side_p7_reg <= side_p6_reg;
        end
    end

    // ---------------- placement, one unit per axis ----------------
    logic signed [W-1:0] u_val, v_val;
    logic                u_sat, v_sat, u_axis, v_axis;

    fpp_place u_place_x (
        .clk      (clk),
        .adv      (adv),
        .dm       (dm_p7_reg),
        .ratio    (side_p7_reg.quo_x),
        .neg      (side_p7_reg.flags.x_neg != dneg_p7_reg),
        .axis_in  (side_p7_reg.flags.on_axis),
        .focal    (focal_x_reg),
        .center   (center_x_reg),
        .value    (u_val),
        .sat      (u_sat),
        .axis_out (u_axis)
    );

    fpp_place u_place_y (
        .clk      (clk),
        .adv      (adv),
        .dm       (dm_p7_reg),
        .ratio    (side_p7_reg.quo_y),
        .neg      (side_p7_reg.flags.y_neg != dneg_p7_reg),
        .axis_in  (side_p7_reg.flags.on_axis),
        .focal    (focal_y_reg),
        .center   (center_y_reg),
        .value    (v_val),
        .sat      (v_sat),
        .axis_out (v_axis)
    );

    // both units carry the same on-axis bit; either one serves
    always_comb
    begin
        pixel.pixel_u   = u_val;
        pixel.pixel_v   = v_val;
        pixel.on_axis   = u_axis & v_axis;
        pixel.saturated = u_sat | v_sat;
    end

endmodule

// ===== design/fpp_checker.sv =====
// Port-level checker for the fisheye projection top level, with its bind.
`include "assert_macros.svh"

module fpp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                point_ready,
    input logic                pixel_valid,
    input logic                pixel_ready,
    input fpp_pkg::fpp_pixel_t pixel
);

    logic out_stall;
    logic u_rail;
    logic v_rail;

    assign out_stall = pixel_valid && !pixel_ready;
    assign u_rail    = (pixel.pixel_u == 32'h7FFF_FFFF) || (pixel.pixel_u == 32'h8000_0000);
    assign v_rail    = (pixel.pixel_v == 32'h7FFF_FFFF) || (pixel.pixel_v == 32'h8000_0000);

    `FPP_ASSERT_NEXT(a_out_hold, out_stall, pixel_valid && $stable(pixel), "word changed in stall")
    `FPP_ASSERT_IMPL(a_ready_free, !pixel_valid, point_ready, "input blocked, output empty")
    `FPP_ASSERT_IMPL(a_stall_blocks, out_stall, !point_ready, "input taken in output stall")
    `FPP_ASSERT_IMPL(a_axis_nosat, pixel_valid && pixel.on_axis, !pixel.saturated, "axis word sat")
    `FPP_ASSERT_IMPL(a_sat_rail, pixel_valid && pixel.saturated, u_rail || v_rail, "sat off rail")

endmodule

bind fisheye_point_project fpp_checker u_fpp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .point_ready (point_ready),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel)
);
